FILE: rtl/bcn_pkg.sv
// ----------------------------------------------------------------------------
// bcn_pkg
// shared format codes, divider codes and stage structs of the texture decoder
// ----------------------------------------------------------------------------
package bcn_pkg;

  localparam logic [3:0] FMT_L8    = 4'd0;
  localparam logic [3:0] FMT_A8    = 4'd1;
  localparam logic [3:0] FMT_R8    = 4'd2;
  localparam logic [3:0] FMT_L8A8  = 4'd3;
  localparam logic [3:0] FMT_R8G8  = 4'd4;
  localparam logic [3:0] FMT_RGBA8 = 4'd5;
  localparam logic [3:0] FMT_BGRA8 = 4'd6;
  localparam logic [3:0] FMT_BC1   = 4'd7;
  localparam logic [3:0] FMT_BC3   = 4'd8;
  localparam logic [3:0] FMT_BC4   = 4'd9;
  localparam logic [3:0] FMT_BC5   = 4'd10;

  typedef logic [2:0][7:0] rgb_t;

  typedef enum logic [2:0] {
    DIV_1,
    DIV_2,
    DIV_3,
    DIV_5,
    DIV_7
  } div_t;

  typedef struct packed {
    logic [10:0] num;
    div_t        dv;
  } chan_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  mode;
    logic [3:0]  idx;
    logic        last;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [31:0] csel;
    rgb_t        c0;
    rgb_t        c1;
    logic        four;
  } job_t;

  typedef struct packed {
    logic            valid;
    logic [1:0]      x;
    logic [1:0]      y;
    logic            last;
    chan_t [3:0]     ch;
  } mix_t;

endpackage

FILE: rtl/bcn_seq.sv
// ----------------------------------------------------------------------------
// bcn_seq
// block register, endpoint widening and texel index counter
// ----------------------------------------------------------------------------
module bcn_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       in_block_low,
  input  logic [63:0]       in_block_high,
  input  logic [3:0]        fmt,
  input  logic              en,
  output bcn_pkg::job_t     job
);

  function automatic bcn_pkg::rgb_t widen565(input logic [15:0] v);
    logic [12:0] t5r;
    logic [12:0] t5b;
    logic [13:0] t6;
    bcn_pkg::rgb_t c;
    t5r  = 13'(v[15:11]) * 13'd255 + 13'd16;
    t6   = 14'(v[10:5]) * 14'd255 + 14'd32;
    t5b  = 13'(v[4:0]) * 13'd255 + 13'd16;
    c[0] = 8'(((t5r >> 5) + t5r) >> 5);
    c[1] = 8'(((t6 >> 6) + t6) >> 6);
    c[2] = 8'(((t5b >> 5) + t5b) >> 5);
    return c;
  endfunction

  logic              busy_r;
  logic [3:0]        idx_r;
  logic [3:0]        mode_r;
  logic [63:0]       lo_r;
  logic [63:0]       hi_r;
  logic [31:0]       csel_r;
  bcn_pkg::rgb_t     c0_r;
  bcn_pkg::rgb_t     c1_r;
  logic              four_r;
  logic [63:0]       cw;
  logic              accept;
  logic              job_last;

  assign cw       = (fmt == bcn_pkg::FMT_BC3) ? in_block_high : in_block_low;
  assign job_last = (mode_r <= bcn_pkg::FMT_BGRA8) || (idx_r == 4'd15);
  assign in_ready = !busy_r || (en && job_last);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 4'd0;
    end else if (accept) begin
      busy_r <= (fmt <= bcn_pkg::FMT_BC5);
      idx_r  <= 4'd0;
    end else if (en && busy_r) begin
      if (job_last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= fmt;
      lo_r   <= in_block_low;
      hi_r   <= in_block_high;
      csel_r <= cw[63:32];
      c0_r   <= widen565(cw[15:0]);
      c1_r   <= widen565(cw[31:16]);
      four_r <= (fmt == bcn_pkg::FMT_BC3) || (cw[15:0] > cw[31:16]);
    end
  end

  always_comb begin
    job.valid = busy_r;
    job.mode  = mode_r;
    job.idx   = idx_r;
    job.last  = job_last;
    job.lo    = lo_r;
    job.hi    = hi_r;
    job.csel  = csel_r;
    job.c0    = c0_r;
    job.c1    = c1_r;
    job.four  = four_r;
  end

endmodule

FILE: rtl/bcn_mix.sv
// ----------------------------------------------------------------------------
// bcn_mix
// per-texel index select, weighted endpoint sums, one texel per cycle when en
// ----------------------------------------------------------------------------
module bcn_mix (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  bcn_pkg::job_t  job,
  output bcn_pkg::mix_t  mix
);

  function automatic bcn_pkg::chan_t lit(input logic [7:0] v);
    bcn_pkg::chan_t r;
    r.num = {3'b000, v};
    r.dv  = bcn_pkg::DIV_1;
    return r;
  endfunction

  function automatic bcn_pkg::chan_t colour(input logic [7:0] c0, input logic [7:0] c1,
                                            input logic [1:0] s, input logic four);
    bcn_pkg::chan_t r;
    r = lit(8'd0);
    case (s)
      2'd0: r = lit(c0);
      2'd1: r = lit(c1);
      2'd2: begin
        if (four) begin
          r.num = {2'b00, c0, 1'b0} + {3'b000, c1};
          r.dv  = bcn_pkg::DIV_3;
        end else begin
          r.num = {3'b000, c0} + {3'b000, c1};
          r.dv  = bcn_pkg::DIV_2;
        end
      end
      2'd3: begin
        if (four) begin
          r.num = {3'b000, c0} + {2'b00, c1, 1'b0};
          r.dv  = bcn_pkg::DIV_3;
        end else begin
          r = lit(8'd0);
        end
      end
      default: r = lit(8'd0);
    endcase
    return r;
  endfunction

  function automatic bcn_pkg::chan_t bc4_chan(input logic [63:0] w, input logic [3:0] i);
    logic [7:0]     a0;
    logic [7:0]     a1;
    logic [47:0]    sw;
    logic [5:0]     pos;
    logic [2:0]     s;
    logic [2:0]     wa;
    logic [2:0]     wb;
    bcn_pkg::chan_t r;
    a0  = w[7:0];
    a1  = w[15:8];
    sw  = w[63:16];
    pos = {2'b00, i} + {1'b0, i, 1'b0};
    s   = sw[pos +: 3];
    wb  = s - 3'd1;
    if (s == 3'd0) begin
      r = lit(a0);
    end else if (s == 3'd1) begin
      r = lit(a1);
    end else if (a0 > a1) begin
      wa    = 3'(4'd8 - {1'b0, s});
      r.num = 11'(wa) * 11'(a0) + 11'(wb) * 11'(a1);
      r.dv  = bcn_pkg::DIV_7;
    end else if (s == 3'd6) begin
      r = lit(8'd0);
    end else if (s == 3'd7) begin
      r = lit(8'd255);
    end else begin
      wa    = 3'd6 - s;
      r.num = 11'(wa) * 11'(a0) + 11'(wb) * 11'(a1);
      r.dv  = bcn_pkg::DIV_5;
    end
    return r;
  endfunction

  logic [7:0]     b0;
  logic [7:0]     b1;
  logic [7:0]     b2;
  logic [7:0]     b3;
  logic [1:0]     cs;
  logic           blk;
  logic           tp3;
  bcn_pkg::mix_t  mix_nxt;
  bcn_pkg::mix_t  mix_r;

  assign b0  = job.lo[7:0];
  assign b1  = job.lo[15:8];
  assign b2  = job.lo[23:16];
  assign b3  = job.lo[31:24];
  assign cs  = job.csel[{job.idx, 1'b0} +: 2];
  assign blk = (job.mode >= bcn_pkg::FMT_BC1);
  assign tp3 = (cs == 2'd3) && !job.four;

  always_comb begin
    mix_nxt.valid = job.valid;
    mix_nxt.x     = blk ? job.idx[1:0] : 2'd0;
    mix_nxt.y     = blk ? job.idx[3:2] : 2'd0;
    mix_nxt.last  = job.last;
    mix_nxt.ch[0] = lit(b0);
    mix_nxt.ch[1] = lit(b0);
    mix_nxt.ch[2] = lit(b0);
    mix_nxt.ch[3] = lit(8'd255);
    case (job.mode)
      bcn_pkg::FMT_L8: begin
      end
      bcn_pkg::FMT_A8: begin
        mix_nxt.ch[0] = lit(8'd0);
        mix_nxt.ch[1] = lit(8'd0);
        mix_nxt.ch[2] = lit(8'd0);
        mix_nxt.ch[3] = lit(b0);
      end
      bcn_pkg::FMT_R8: begin
        mix_nxt.ch[1] = lit(8'd0);
        mix_nxt.ch[2] = lit(8'd0);
      end
      bcn_pkg::FMT_L8A8: begin
        mix_nxt.ch[3] = lit(b1);
      end
      bcn_pkg::FMT_R8G8: begin
        mix_nxt.ch[1] = lit(b1);
        mix_nxt.ch[2] = lit(8'd0);
      end
      bcn_pkg::FMT_RGBA8: begin
        mix_nxt.ch[1] = lit(b1);
        mix_nxt.ch[2] = lit(b2);
        mix_nxt.ch[3] = lit(b3);
      end
      bcn_pkg::FMT_BGRA8: begin
        mix_nxt.ch[0] = lit(b2);
        mix_nxt.ch[1] = lit(b1);
        mix_nxt.ch[2] = lit(b0);
        mix_nxt.ch[3] = lit(b3);
      end
      bcn_pkg::FMT_BC1: begin
        mix_nxt.ch[0] = colour(job.c0[0], job.c1[0], cs, job.four);
        mix_nxt.ch[1] = colour(job.c0[1], job.c1[1], cs, job.four);
        mix_nxt.ch[2] = colour(job.c0[2], job.c1[2], cs, job.four);
        mix_nxt.ch[3] = lit(tp3 ? 8'd0 : 8'd255);
      end
      bcn_pkg::FMT_BC3: begin
        mix_nxt.ch[0] = colour(job.c0[0], job.c1[0], cs, 1'b1);
        mix_nxt.ch[1] = colour(job.c0[1], job.c1[1], cs, 1'b1);
        mix_nxt.ch[2] = colour(job.c0[2], job.c1[2], cs, 1'b1);
        mix_nxt.ch[3] = bc4_chan(job.lo, job.idx);
      end
      bcn_pkg::FMT_BC4: begin
        mix_nxt.ch[0] = bc4_chan(job.lo, job.idx);
        mix_nxt.ch[1] = mix_nxt.ch[0];
        mix_nxt.ch[2] = mix_nxt.ch[0];
      end
      bcn_pkg::FMT_BC5: begin
        mix_nxt.ch[0] = bc4_chan(job.lo, job.idx);
        mix_nxt.ch[1] = bc4_chan(job.hi, job.idx);
        mix_nxt.ch[2] = lit(8'd0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_r.valid <= 1'b0;
    end else if (en) begin
      mix_r.valid <= mix_nxt.valid;
    end
    if (en) begin
      mix_r.x    <= mix_nxt.x;
      mix_r.y    <= mix_nxt.y;
      mix_r.last <= mix_nxt.last;
      mix_r.ch   <= mix_nxt.ch;
    end
  end

  assign mix = mix_r;

endmodule

FILE: rtl/bcn_out.sv
// ----------------------------------------------------------------------------
// bcn_out
// constant divide of the weighted sums and the result register
// ----------------------------------------------------------------------------
module bcn_out (
  input  logic           clk,
  input  logic           rst_n,
  input  bcn_pkg::mix_t  mix,
  input  logic           out_ready,
  output logic           out_valid,
  output logic           en,
  output logic [7:0]     out_red,
  output logic [7:0]     out_green,
  output logic [7:0]     out_blue,
  output logic [7:0]     out_alpha,
  output logic [1:0]     out_texel_x,
  output logic [1:0]     out_texel_y,
  output logic           out_last_texel
);

  // reciprocal multiply, exact over the range of each divisor
  function automatic logic [7:0] cdiv(input bcn_pkg::chan_t c);
    logic [22:0] k;
    logic [22:0] p;
    logic [7:0]  q;
    k = 23'd0;
    case (c.dv)
      bcn_pkg::DIV_3: k = 23'd1366;
      bcn_pkg::DIV_5: k = 23'd3277;
      bcn_pkg::DIV_7: k = 23'd2341;
      default:        k = 23'd0;
    endcase
    p = 23'(c.num) * k;
    case (c.dv)
      bcn_pkg::DIV_1: q = c.num[7:0];
      bcn_pkg::DIV_2: q = c.num[8:1];
      bcn_pkg::DIV_3: q = p[19:12];
      bcn_pkg::DIV_5: q = p[21:14];
      bcn_pkg::DIV_7: q = p[21:14];
      default:        q = c.num[7:0];
    endcase
    return q;
  endfunction

  logic        out_valid_r;
  logic [7:0]  red_r;
  logic [7:0]  green_r;
  logic [7:0]  blue_r;
  logic [7:0]  alpha_r;
  logic [1:0]  x_r;
  logic [1:0]  y_r;
  logic        last_r;

  assign en = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && mix.valid) begin
      red_r   <= cdiv(mix.ch[0]);
      green_r <= cdiv(mix.ch[1]);
      blue_r  <= cdiv(mix.ch[2]);
      alpha_r <= cdiv(mix.ch[3]);
      x_r     <= mix.x;
      y_r     <= mix.y;
      last_r  <= mix.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_alpha      = alpha_r;
  assign out_texel_x    = x_r;
  assign out_texel_y    = y_r;
  assign out_last_texel = last_r;

endmodule

FILE: rtl/bcn_texture_block_decoder_unit.sv
// ----------------------------------------------------------------------------
// bcn_texture_block_decoder_unit
// pipeline: block register, mix register, then the result register
// throughput: one texel per cycle from the block register unless the output
//   stalls; a bc block gives 16 texels, a raw item one, unused codes dropped
// reset: synchronous, pipeline emptied, format register set to bc1
// ----------------------------------------------------------------------------
module bcn_texture_block_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_block_low,
  input  logic [63:0] in_block_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [1:0]  out_texel_x,
  output logic [1:0]  out_texel_y,
  output logic        out_last_texel
);

  logic [3:0]     fmt_r;
  logic           en;
  bcn_pkg::job_t  job;
  bcn_pkg::mix_t  mix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= bcn_pkg::FMT_BC1;
    end else if (cfg_we) begin
      fmt_r <= cfg_wdata;
    end
  end

  bcn_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_block_low  (in_block_low),
    .in_block_high (in_block_high),
    .fmt           (fmt_r),
    .en            (en),
    .job           (job)
  );

  bcn_mix u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .job   (job),
    .mix   (mix)
  );

  bcn_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .mix            (mix),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .en             (en),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_texel_x    (out_texel_x),
    .out_texel_y    (out_texel_y),
    .out_last_texel (out_last_texel)
  );

endmodule

FILE: verif/bcn_texture_block_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// bcn_texture_block_decoder_unit_tb
// self-checking bench for the texture block decoder. a queue-fed driver sends
// compressed blocks and raw texels under every format code, a monitor compares
// each texel with a local decoder model, and both sides stall at random
// ----------------------------------------------------------------------------
module bcn_texture_block_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] FMT_MAX      = 4'hF;
  localparam int         RAND_ITEMS   = 370;
  localparam int         SETTLE       = 8;
  localparam int         LIMIT_CYCLES = 2_000_000;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } blk_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [1:0] texel_x;
    logic [1:0] texel_y;
    logic       last_texel;
  } texel_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        cfg_we         = 1'b0;
  logic [3:0]  cfg_wdata      = '0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [63:0] in_block_low   = '0;
  logic [63:0] in_block_high  = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic [1:0]  out_texel_x;
  logic [1:0]  out_texel_y;
  logic        out_last_texel;

  blk_t        block_q[$];
  texel_t      texel_q[$];
  logic [3:0]  fmt_shadow     = bcn_pkg::FMT_BC1;
  logic        calm           = 1'b0;
  int          errors         = 0;
  int          items_accepted = 0;
  int          texels_checked = 0;
  int          fmt_writes     = 0;
  int          rand_items     = 0;
  int          cycles         = 0;
  int          drv_gap        = 0;
  int          rdy_stall      = 0;
  blk_t        cur_blk;
  texel_t      want;

  bcn_texture_block_decoder_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_block_low   (in_block_low),
    .in_block_high  (in_block_high),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_texel_x    (out_texel_x),
    .out_texel_y    (out_texel_y),
    .out_last_texel (out_last_texel)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] widen(int v, int bits);
    int sc;
    int t;
    sc = 1 << bits;
    t  = v * 255 + sc / 2;
    return 8'((t / sc + t) / sc);
  endfunction

  function automatic bcn_pkg::rgb_t widen565(logic [15:0] e);
    bcn_pkg::rgb_t c;
    c[0] = widen(int'(e[15:11]), 5);
    c[1] = widen(int'(e[10:5]), 6);
    c[2] = widen(int'(e[4:0]), 5);
    return c;
  endfunction

  function automatic texel_t colour_pick(bcn_pkg::rgb_t c0, bcn_pkg::rgb_t c1,
                                         logic [1:0] s, logic four);
    texel_t        px;
    bcn_pkg::rgb_t col;
    int            k;
    int            a;
    int            b;
    px = '0;
    px.alpha = 8'hFF;
    for (k = 0; k < 3; k++) begin
      a = int'(c0[k]);
      b = int'(c1[k]);
      case (s)
        2'd0: col[k] = c0[k];
        2'd1: col[k] = c1[k];
        2'd2: col[k] = four ? 8'((2 * a + b) / 3) : 8'((a + b) / 2);
        default: col[k] = four ? 8'((a + 2 * b) / 3) : 8'h00;
      endcase
    end
    if (s == 2'd3 && !four) px.alpha = 8'h00;
    px.red   = col[0];
    px.green = col[1];
    px.blue  = col[2];
    return px;
  endfunction

  function automatic logic [7:0] bc4_value(logic [63:0] w, int i);
    int a0;
    int a1;
    int s;
    a0 = int'(w[7:0]);
    a1 = int'(w[15:8]);
    s  = int'(w[16 + 3 * i +: 3]);
    if (s == 0) return w[7:0];
    if (s == 1) return w[15:8];
    if (a0 > a1) return 8'(((8 - s) * a0 + (s - 1) * a1) / 7);
    if (s == 6) return 8'h00;
    if (s == 7) return 8'hFF;
    return 8'(((6 - s) * a0 + (s - 1) * a1) / 5);
  endfunction

  // decode one accepted item into the texels it should produce
  function automatic void predict_texels(logic [3:0] fmt, logic [63:0] lo, logic [63:0] hi);
    texel_t        px;
    bcn_pkg::rgb_t c0;
    bcn_pkg::rgb_t c1;
    logic [63:0]   cw;
    logic [15:0]   e0;
    logic [15:0]   e1;
    logic [31:0]   sel;
    logic [7:0]    v;
    int            i;
    px = '0;
    if (fmt <= bcn_pkg::FMT_BGRA8) begin
      px.alpha = 8'hFF;
      px.last_texel = 1'b1;
      case (fmt)
        bcn_pkg::FMT_L8: begin
          px.red = lo[7:0]; px.green = lo[7:0]; px.blue = lo[7:0];
        end
        bcn_pkg::FMT_A8: px.alpha = lo[7:0];
        bcn_pkg::FMT_R8: px.red = lo[7:0];
        bcn_pkg::FMT_L8A8: begin
          px.red = lo[7:0]; px.green = lo[7:0]; px.blue = lo[7:0]; px.alpha = lo[15:8];
        end
        bcn_pkg::FMT_R8G8: begin
          px.red = lo[7:0]; px.green = lo[15:8];
        end
        bcn_pkg::FMT_RGBA8: begin
          px.red = lo[7:0]; px.green = lo[15:8]; px.blue = lo[23:16]; px.alpha = lo[31:24];
        end
        default: begin
          px.red = lo[23:16]; px.green = lo[15:8]; px.blue = lo[7:0]; px.alpha = lo[31:24];
        end
      endcase
      texel_q.push_back(px);
    end else if (fmt <= bcn_pkg::FMT_BC5) begin
      cw  = (fmt == bcn_pkg::FMT_BC3) ? hi : lo;
      e0  = cw[15:0];
      e1  = cw[31:16];
      sel = cw[63:32];
      c0  = widen565(e0);
      c1  = widen565(e1);
      for (i = 0; i < 16; i++) begin
        case (fmt)
          bcn_pkg::FMT_BC1: px = colour_pick(c0, c1, sel[2 * i +: 2], e0 > e1);
          bcn_pkg::FMT_BC3: begin
            px = colour_pick(c0, c1, sel[2 * i +: 2], 1'b1);
            px.alpha = bc4_value(lo, i);
          end
          bcn_pkg::FMT_BC4: begin
            v = bc4_value(lo, i);
            px.red = v; px.green = v; px.blue = v; px.alpha = 8'hFF;
          end
          default: begin
            px.red = bc4_value(lo, i); px.green = bc4_value(hi, i);
            px.blue = 8'h00; px.alpha = 8'hFF;
          end
        endcase
        px.texel_x = 2'(i);
        px.texel_y = 2'(i >> 2);
        px.last_texel = (i == 15);
        texel_q.push_back(px);
      end
    end
  endfunction

  function automatic logic [63:0] shape_alpha(logic [63:0] w);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) w[15:8] = w[7:0];
    else if (r == 1) w[15:0] = $urandom_range(0, 1) ? 16'h00FF : 16'hFF00;
    return w;
  endfunction

  function automatic logic [63:0] shape_colour(logic [63:0] w);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) w[31:16] = w[15:0];
    else if (r == 1) w[31:0] = $urandom_range(0, 1) ? 32'h0000FFFF : 32'hFFFF0000;
    return w;
  endfunction

  function automatic blk_t rand_blk(logic [3:0] fmt);
    blk_t b;
    int   r;
    b.lo = {$urandom, $urandom};
    b.hi = {$urandom, $urandom};
    case (fmt)
      bcn_pkg::FMT_BC1: b.lo = shape_colour(b.lo);
      bcn_pkg::FMT_BC3: begin
        b.lo = shape_alpha(b.lo);
        b.hi = shape_colour(b.hi);
      end
      bcn_pkg::FMT_BC4: b.lo = shape_alpha(b.lo);
      bcn_pkg::FMT_BC5: begin
        b.lo = shape_alpha(b.lo);
        b.hi = shape_alpha(b.hi);
      end
      default: begin
        r = $urandom_range(0, 9);
        if (r == 0) b.lo = '0;
        else if (r == 1) b.lo = '1;
      end
    endcase
    return b;
  endfunction

  task automatic push_blk(logic [63:0] lo, logic [63:0] hi);
    blk_t b;
    b.lo = lo;
    b.hi = hi;
    block_q.push_back(b);
  endtask

  task automatic drain_all();
    do @(negedge clk); while (block_q.size() != 0 || in_valid || texel_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_fmt(logic [3:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    fmt_shadow = v;
    fmt_writes++;
    @(negedge clk);
  endtask

  task automatic check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_texels(fmt_shadow, in_block_low, in_block_high);
        items_accepted++;
        drv_gap = pick_gap();
      end
      if (!(in_valid && !in_ready)) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid <= 1'b0;
        end else if (block_q.size() != 0) begin
          cur_blk = block_q.pop_front();
          in_block_low  <= cur_blk.lo;
          in_block_high <= cur_blk.hi;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rdy_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (texel_q.size() == 0) begin
          $error("texel out with no item pending");
          errors++;
        end else begin
          want = texel_q.pop_front();
          check_field("red", int'(want.red), int'(out_red));
          check_field("green", int'(want.green), int'(out_green));
          check_field("blue", int'(want.blue), int'(out_blue));
          check_field("alpha", int'(want.alpha), int'(out_alpha));
          check_field("texel_x", int'(want.texel_x), int'(out_texel_x));
          check_field("texel_y", int'(want.texel_y), int'(out_texel_y));
          check_field("last_texel", int'(want.last_texel), int'(out_last_texel));
          texels_checked++;
        end
      end
      if (rdy_stall > 0) begin
        rdy_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rdy_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int   m;
    int   n;
    int   k;
    blk_t b;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // bc1 out of reset: four colour, three colour, equal endpoints, extremes
    push_blk({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, '0);
    push_blk({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, '1);
    push_blk({32'hE4E4E4E4, 16'h8410, 16'h8410}, '0);
    push_blk('0, '1);
    push_blk('1, '0);
    push_blk({32'h1B1B1B1B, 16'h07E0, 16'hF800}, {$urandom, $urandom});
    drain_all();

    for (m = bcn_pkg::FMT_L8; m <= FMT_MAX; m++) begin
      if (m == bcn_pkg::FMT_BC1) continue;
      write_fmt(4'(m));
      case (4'(m))
        bcn_pkg::FMT_BC3: begin
          push_blk({24'hFAC688, 24'hFAC688, 8'h10, 8'hF0},
                   {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
          push_blk({24'hFAC688, 24'hFAC688, 8'hF0, 8'h10},
                   {32'h1B1B1B1B, 16'h0000, 16'hFFFF});
        end
        bcn_pkg::FMT_BC4: begin
          push_blk({24'hFAC688, 24'hFAC688, 8'h10, 8'hF0}, '1);
          push_blk({24'hFAC688, 24'hFAC688, 8'hF0, 8'h10}, '0);
          push_blk({24'hFAC688, 24'hFAC688, 8'h77, 8'h77}, '1);
          push_blk({24'hFAC688, 24'hFAC688, 8'hFF, 8'h00}, '0);
        end
        bcn_pkg::FMT_BC5: begin
          push_blk({24'hFAC688, 24'hFAC688, 8'h20, 8'hE0},
                   {24'hFAC688, 24'hFAC688, 8'hFF, 8'h00});
          push_blk({24'hFAC688, 24'hFAC688, 8'hFF, 8'h00},
                   {24'hFAC688, 24'hFAC688, 8'h20, 8'hE0});
        end
        default: push_blk(64'h0123456789ABCDEF, '1);
      endcase
      drain_all();
    end

    // random phases, each under one format setting
    while (rand_items < RAND_ITEMS) begin
      k = $urandom_range(0, 19);
      m = (k < 18) ? $urandom_range(bcn_pkg::FMT_L8, bcn_pkg::FMT_BC5)
                   : $urandom_range(bcn_pkg::FMT_BC5 + 1, FMT_MAX);
      n = $urandom_range(5, 30);
      calm = ($urandom_range(0, 4) == 0);
      write_fmt(4'(m));
      if (m > bcn_pkg::FMT_BC5) n = n / 3 + 1;
      for (k = 0; k < n; k++) begin
        b = rand_blk(4'(m));
        push_blk(b.lo, b.hi);
        if (m <= bcn_pkg::FMT_BC5) rand_items++;
        // hold the sender mid phase until the decoder has emptied
        if (n >= 20 && k == n / 2) drain_all();
      end
      drain_all();
    end

    $display("%0d items accepted and %0d texels checked over %0d format register writes",
             items_accepted, texels_checked, fmt_writes);
    $display("all eleven formats plus unused codes, with random stalls on both channels");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
